### hw/rtl/psdp_pkg.sv
// Shared types and constants for the 2x2 positive semidefinite projection.
// No dependencies; used by psd_projection_2x2.
package psdp_pkg;

	// Result classification carried with every item
	typedef enum logic [1:0] {
		OUTCOME_KEEP  = 2'd0,
		OUTCOME_CLAMP = 2'd1,
		OUTCOME_ZERO  = 2'd2
	} outcome_t;

endpackage

### hw/rtl/psd_projection_2x2.sv
// Top level: 2x2 eigenvalue-clamp projection onto the semidefinite cone.
// Uses psdp_pkg, psdp_sqrt_pipe and psdp_div_pipe.
//
//   channel   | valid     | stall     | payload
//   ----------+-----------+-----------+------------------------------------------
//   input     | in_valid  | in_stall  | entry_00, entry_01, entry_10, entry_11
//   output    | out_valid | out_stall | out_00..out_11, outcome, saturated
//
// One matrix enters per cycle while no valid output stalls; depth is set by the
// square root (DATA_WIDTH+1 bit stages) and the divider (DATA_WIDTH+1 bit stages).
// Reset clears only the valid bits of the pipeline.
// A stalled valid output holds the whole pipeline; in_stall follows at once.
module psd_projection_2x2 #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_WIDTH-1:0] entry_00,
	input  logic [DATA_WIDTH-1:0] entry_01,
	input  logic [DATA_WIDTH-1:0] entry_10,
	input  logic [DATA_WIDTH-1:0] entry_11,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] out_00,
	output logic [DATA_WIDTH-1:0] out_01,
	output logic [DATA_WIDTH-1:0] out_10,
	output logic [DATA_WIDTH-1:0] out_11,
	output logic [1:0]            outcome,
	output logic                  saturated
);

	localparam int W  = DATA_WIDTH;
	localparam int QW = 2 * W + 2;   // radicand
	localparam int RW = W + 1;       // root
	localparam int NW = 2 * W + 5;   // rounded numerator
	localparam int DW = W + 3;       // divisor 4R
	localparam int QB = W + 1;       // quotient bits examined
	localparam logic [QB-1:0] LIM_POS = {2'b00, {(W - 1){1'b1}}};
	localparam logic [QB-1:0] LIM_NEG = {2'b01, {(W - 1){1'b0}}};

	typedef struct packed {
		logic [3:0][W-1:0]   raw;
		logic signed [W:0]   s;
		logic signed [W:0]   diff;
		logic signed [W:0]   bs;
		psdp_pkg::outcome_t  kind;
	} root_side_t;

	typedef struct packed {
		logic [3:0][W-1:0]   raw;
		psdp_pkg::outcome_t  kind;
		logic                bs_neg;
	} div_side_t;

	logic en;

	// Advance everything unless a finished result is held back
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: capture the transfer
	logic [3:0][W-1:0] raw_s1;
	logic              v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1 <= {entry_11, entry_10, entry_01, entry_00};
		end
	end

	// Stage 2: sums and differences
	logic [3:0][W-1:0] raw_s2;
	logic signed [W-1:0] a_s2, d_s2;
	logic signed [W:0]   bs_s2, s_s2, diff_s2;
	logic                v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s2  <= raw_s1;
			a_s2    <= $signed(raw_s1[0]);
			d_s2    <= $signed(raw_s1[3]);
			bs_s2   <= $signed({raw_s1[1][W-1], raw_s1[1]}) + $signed({raw_s1[2][W-1], raw_s1[2]});
			s_s2    <= $signed({raw_s1[0][W-1], raw_s1[0]}) + $signed({raw_s1[3][W-1], raw_s1[3]});
			diff_s2 <= $signed({raw_s1[0][W-1], raw_s1[0]}) - $signed({raw_s1[3][W-1], raw_s1[3]});
		end
	end

	// Stage 3: squares and the diagonal product
	logic [3:0][W-1:0]     raw_s3;
	logic signed [W:0]     bs_s3, s_s3, diff_s3;
	logic signed [2*W-1:0] ad_s3;
	logic signed [2*W+1:0] bs2_s3, diff2_s3;
	logic                  v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s3   <= raw_s2;
			bs_s3    <= bs_s2;
			s_s3     <= s_s2;
			diff_s3  <= diff_s2;
			ad_s3    <= a_s2 * d_s2;
			bs2_s3   <= bs_s2 * bs_s2;
			diff2_s3 <= diff_s2 * diff_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Classify by the sign of 4ad - B^2 and of the trace
	logic signed [2*W+3:0] det4;
	logic                  det_neg;
	logic [QW-1:0]         radicand;
	root_side_t            rside_in, rside_out;
	logic                  v_root;
	logic [RW-1:0]         root;

	assign det4     = $signed({ad_s3[2*W-1], ad_s3[2*W-1], ad_s3, 2'b00})
	                - $signed({2'b00, bs2_s3});
	assign det_neg  = det4[2*W+3];
	assign radicand = QW'($unsigned(diff2_s3) + $unsigned(bs2_s3));

	always_comb begin
		rside_in.raw  = raw_s3;
		rside_in.s    = s_s3;
		rside_in.diff = diff_s3;
		rside_in.bs   = bs_s3;
		if (det_neg) begin
			rside_in.kind = psdp_pkg::OUTCOME_CLAMP;
		end else if (s_s3[W]) begin
			rside_in.kind = psdp_pkg::OUTCOME_ZERO;
		end else begin
			rside_in.kind = psdp_pkg::OUTCOME_KEEP;
		end
	end

	psdp_sqrt_pipe #(
		.QW(QW),
		.RW(RW),
		.SW($bits(root_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.radicand (radicand),
		.side_in  (rside_in),
		.out_valid(v_root),
		.root     (root),
		.side_out (rside_out)
	);

	// Stage 5: eigenvector terms around the root
	logic [RW-1:0]        r_fix;
	logic signed [W+2:0]  sp_w, n00_w, n11_w;
	logic [W+1:0]         sp_s5, n00_s5, n11_s5;
	logic [W:0]           bmag_s5;
	logic [RW-1:0]        r_s5;
	div_side_t            dside_s5;
	logic                 v_s5;

	assign r_fix = (root == '0) ? RW'(1) : root;
	assign sp_w  = (W + 3)'(rside_out.s) + $signed({2'b00, r_fix});
	assign n00_w = (W + 3)'(rside_out.diff) + $signed({2'b00, r_fix});
	assign n11_w = $signed({2'b00, r_fix}) - (W + 3)'(rside_out.diff);

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s5           <= sp_w[W+1:0];
			n00_s5          <= n00_w[W+1:0];
			n11_s5          <= n11_w[W+1:0];
			bmag_s5         <= rside_out.bs[W] ? $unsigned(-rside_out.bs) : $unsigned(rside_out.bs);
			r_s5            <= r_fix;
			dside_s5.raw    <= rside_out.raw;
			dside_s5.kind   <= rside_out.kind;
			dside_s5.bs_neg <= rside_out.bs[W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_root;
		end
	end

	// Rounded numerators: product plus half the divisor
	logic [2:0][NW-1:0] num;
	logic [DW-1:0]      den;

	assign num[0] = NW'(sp_s5) * NW'(n00_s5) + NW'({r_s5, 1'b0});
	assign num[1] = NW'(sp_s5) * NW'(bmag_s5) + NW'({r_s5, 1'b0});
	assign num[2] = NW'(sp_s5) * NW'(n11_s5) + NW'({r_s5, 1'b0});
	assign den    = {r_s5, 2'b00};

	logic [2:0][QB-1:0] quot;
	logic [2:0]         ovf;
	div_side_t          dside_out;
	logic               v_div;

	psdp_div_pipe #(
		.NW(NW),
		.DW(DW),
		.QB(QB),
		.LANES(3),
		.SW($bits(div_side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.num      (num),
		.den      (den),
		.side_in  (dside_s5),
		.out_valid(v_div),
		.quot     (quot),
		.ovf      (ovf),
		.side_out (dside_out)
	);

	// Clip each magnitude, apply the sign
	logic [2:0][W-1:0] val;
	logic [2:0]        clip;

	for (genvar l = 0; l < 3; l++) begin : g_clip
		logic [QB-1:0] lim;
		logic [QB-1:0] m;
		logic          neg;

		assign neg     = (l == 1) && dside_out.bs_neg;
		assign lim     = neg ? LIM_NEG : LIM_POS;
		assign clip[l] = ovf[l] || (quot[l] > lim);
		assign m       = clip[l] ? lim : quot[l];
		assign val[l]  = neg ? W'(-m) : W'(m);
	end

	// Output register
	logic [3:0][W-1:0] res_q;
	logic [1:0]        outcome_q;
	logic              sat_q;
	logic              out_valid_q;

	always_ff @(posedge clk) begin
		if (en) begin
			outcome_q <= dside_out.kind;
			case (dside_out.kind)
				psdp_pkg::OUTCOME_CLAMP: begin
					res_q <= {val[2], val[1], val[1], val[0]};
					sat_q <= |clip;
				end
				psdp_pkg::OUTCOME_KEEP: begin
					res_q <= dside_out.raw;
					sat_q <= 1'b0;
				end
				default: begin
					res_q <= '0;
					sat_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_div;
		end
	end

	assign out_valid = out_valid_q;
	assign out_00    = res_q[0];
	assign out_01    = res_q[1];
	assign out_10    = res_q[2];
	assign out_11    = res_q[3];
	assign outcome   = outcome_q;
	assign saturated = sat_q;

endmodule

### hw/rtl/psdp_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Carries an opaque side vector alongside; no package dependencies.
module psdp_sqrt_pipe #(
	parameter int QW = 66,
	parameter int RW = 33,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [QW-1:0] radicand,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [RW-1:0] root,
	output logic [SW-1:0] side_out
);

	logic [QW-1:0] rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [SW-1:0] side_s [RW+1];
	logic [RW:0]   v_s;

	// Capture the radicand with an empty root
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= radicand;
			root_s[0] <= '0;
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[RW-1:0], in_valid};
		end
	end

	// Each stage settles one root bit, highest first
	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int I = RW - 1 - k;
		logic [QW:0] term;
		logic        take;

		assign term = ((QW + 1)'(root_s[k]) << (I + 1)) | ((QW + 1)'(1) << (2 * I));
		assign take = {1'b0, rem_s[k]} >= term;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? QW'({1'b0, rem_s[k]} - term) : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] | (RW'(1) << I)) : root_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];

endmodule

### hw/rtl/psdp_div_pipe.sv
// Pipelined restoring divider, several numerator lanes over one shared divisor.
// Flags quotients that do not fit QB bits; no package dependencies.
module psdp_div_pipe #(
	parameter int NW = 69,
	parameter int DW = 35,
	parameter int QB = 33,
	parameter int LANES = 3,
	parameter int SW = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [LANES-1:0][NW-1:0]  num,
	input  logic [DW-1:0]             den,
	input  logic [SW-1:0]             side_in,
	output logic                      out_valid,
	output logic [LANES-1:0][QB-1:0]  quot,
	output logic [LANES-1:0]          ovf,
	output logic [SW-1:0]             side_out
);

	logic [LANES-1:0][NW-1:0] rem_s  [QB+1];
	logic [LANES-1:0][QB-1:0] quot_s [QB+1];
	logic [LANES-1:0]         ovf_s  [QB+1];
	logic [DW-1:0]            den_s  [QB+1];
	logic [SW-1:0]            side_s [QB+1];
	logic [QB:0]              v_s;

	// Capture numerators and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			quot_s[0] <= '0;
			ovf_s[0]  <= '0;
			den_s[0]  <= den;
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QB-1:0], in_valid};
		end
	end

	// One quotient bit per stage; the first stage also checks for overflow
	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int I = QB - 1 - k;
		logic [NW-1:0]    shifted;
		logic [LANES-1:0] take;
		logic [LANES-1:0] big;

		assign shifted = NW'(den_s[k]) << I;

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			assign take[l] = rem_s[k][l] >= shifted;
			if (k == 0) begin : g_ovf
				assign big[l] = rem_s[k][l] >= (NW'(den_s[k]) << QB);
			end else begin : g_noovf
				assign big[l] = 1'b0;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l]  <= take[l] ? rem_s[k][l] - shifted : rem_s[k][l];
					quot_s[k+1][l] <= quot_s[k][l] | (take[l] ? QB'(1) << I : '0);
					ovf_s[k+1][l]  <= ovf_s[k][l] | big[l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign quot      = quot_s[QB];
	assign ovf       = ovf_s[QB];
	assign side_out  = side_s[QB];

endmodule

### test/tb_psd_projection_2x2.sv
// Testbench for psd_projection_2x2: directed and random matrices checked against
// an in-bench eigenvalue-clamp predictor. Depends on psdp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_psd_projection_2x2;

	localparam int DW = 32;
	localparam int N_RANDOM = 700;
	localparam logic [DW-1:0] MAXV = 32'h7fffffff;
	localparam logic [DW-1:0] MINV = 32'h80000000;

	typedef struct {
		logic [DW-1:0]      m00, m01, m10, m11;
		psdp_pkg::outcome_t kind;
		logic               sat;
	} proj_t;

	// Expected projections, oldest first
	class proj_board;
		proj_t pending[$];
		int    errors = 0;

		function automatic logic [127:0] isqrt(input logic [127:0] v);
			logic [127:0] res, t;
			res = 0;
			for (int i = 40; i >= 0; i--) begin
				t = res | (128'd1 << i);
				if (t * t <= v) res = t;
			end
			return res;
		endfunction

		// round(x*y / 4r) with sign, clipped to range
		function automatic logic [DW-1:0] scale(input logic [127:0] x, input logic [127:0] y,
				input logic neg, input logic [127:0] r, inout logic sat);
			logic [127:0] q, lim;
			lim = neg ? 128'h80000000 : 128'h7fffffff;
			q = (x * y + 2 * r) / (4 * r);
			if (q > lim) begin
				q = lim;
				sat = 1'b1;
			end
			return neg ? DW'(-q) : DW'(q);
		endfunction

		function automatic proj_t project(input logic [DW-1:0] e00, input logic [DW-1:0] e01,
				input logic [DW-1:0] e10, input logic [DW-1:0] e11);
			proj_t p;
			logic signed [127:0] a, d, bs, s, diff, det;
			logic [127:0] r, mb;
			a = 128'(signed'(e00));
			d = 128'(signed'(e11));
			bs = 128'(signed'(e01)) + 128'(signed'(e10));
			s = a + d;
			diff = a - d;
			det = 4 * a * d - bs * bs;
			p.sat = 1'b0;
			if (det >= 0) begin
				if (s >= 0) begin
					p.m00 = e00; p.m01 = e01; p.m10 = e10; p.m11 = e11;
					p.kind = psdp_pkg::OUTCOME_KEEP;
				end else begin
					p.m00 = 0; p.m01 = 0; p.m10 = 0; p.m11 = 0;
					p.kind = psdp_pkg::OUTCOME_ZERO;
				end
				return p;
			end
			r = isqrt(diff * diff + bs * bs);
			if (r == 0) r = 1;
			mb = bs < 0 ? -bs : bs;
			p.m00 = scale(s + r, diff + r, 1'b0, r, p.sat);
			p.m01 = scale(s + r, mb, bs < 0, r, p.sat);
			p.m10 = p.m01;
			p.m11 = scale(s + r, r - diff, 1'b0, r, p.sat);
			p.kind = psdp_pkg::OUTCOME_CLAMP;
			return p;
		endfunction

		function void note(input logic [DW-1:0] e00, input logic [DW-1:0] e01,
				input logic [DW-1:0] e10, input logic [DW-1:0] e11);
			pending.push_back(project(e00, e01, e10, e11));
		endfunction

		function void check(input proj_t got);
			proj_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %h", $time,
					got.m00, got.m01, got.m10, got.m11);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.m00 !== want.m00) begin
				$display("%0t: out_00 exp %h got %h", $time, want.m00, got.m00); errors++;
			end
			if (got.m01 !== want.m01) begin
				$display("%0t: out_01 exp %h got %h", $time, want.m01, got.m01); errors++;
			end
			if (got.m10 !== want.m10) begin
				$display("%0t: out_10 exp %h got %h", $time, want.m10, got.m10); errors++;
			end
			if (got.m11 !== want.m11) begin
				$display("%0t: out_11 exp %h got %h", $time, want.m11, got.m11); errors++;
			end
			if (got.kind !== want.kind) begin
				$display("%0t: outcome exp %0d got %0d", $time, want.kind, got.kind); errors++;
			end
			if (got.sat !== want.sat) begin
				$display("%0t: saturated exp %b got %b", $time, want.sat, got.sat); errors++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [DW-1:0] entry_00 = '0, entry_01 = '0, entry_10 = '0, entry_11 = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [DW-1:0] out_00, out_01, out_10, out_11;
	logic [1:0]    outcome;
	logic          saturated;

	proj_board board = new();
	int            idle_pct = 38;
	int            cycle = 0;

	psd_projection_2x2 #(.DATA_WIDTH(DW)) i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Record accepted transfers on both channels
	always @(posedge clk) begin
		proj_t got;
		cycle <= cycle + 1;
		if (arst_n && in_valid && !in_stall)
			board.note(entry_00, entry_01, entry_10, entry_11);
		if (arst_n && out_valid && !out_stall) begin
			got.m00 = out_00; got.m01 = out_01; got.m10 = out_10; got.m11 = out_11;
			got.kind = psdp_pkg::outcome_t'(outcome);
			got.sat = saturated;
			board.check(got);
		end
	end

	// Receiver: random stalls, a quiet window, and one long hold-off
	always @(posedge clk) begin
		if (cycle >= 900 && cycle < 1200)
			out_stall <= 1'b0;
		else if (cycle >= 300 && cycle < 600)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < 38);
	end

	task automatic send(input logic [DW-1:0] e00, input logic [DW-1:0] e01,
			input logic [DW-1:0] e10, input logic [DW-1:0] e11);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		entry_00 <= e00; entry_01 <= e01; entry_10 <= e10; entry_11 <= e11;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [DW-1:0] pick(input int mode);
		case (mode)
			0: return $urandom();
			1: return DW'(int'($urandom_range(2 * 1048576)) - 1048576);
			2: return DW'(int'($urandom_range(512)) - 256) << $urandom_range(24);
			default: return $urandom_range(3) == 0 ? ($urandom_range(1) ? MAXV : MINV)
				: DW'(int'($urandom_range(8)) - 4);
		endcase
	endfunction

	initial begin
		logic [DW-1:0] b;
		int mode;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, pass-through, zeroing, clamping, diagonal cases
		send('0, '0, '0, '0);
		send(MAXV, MAXV, MAXV, MAXV);
		send(MINV, MINV, MINV, MINV);
		send(MAXV, MINV, MINV, MINV);
		send(MAXV, MAXV, MAXV, MINV);
		send(MINV, MAXV, MINV, MAXV);
		send(32'h00010000, '0, '0, 32'h00010000);
		send(32'hffff0000, '0, '0, 32'hffff0000);
		send(32'h00030000, '0, '0, 32'hfffe0000);
		send(32'hfffe0000, '0, '0, 32'h00030000);
		send(32'h00020000, 32'h00050000, 32'hfffc0000, 32'h00020000);
		send(32'h00010000, 32'h00020000, 32'h00020000, 32'h00010000);
		send(32'hffff0000, 32'h00020000, 32'h00020000, 32'hffff0000);
		send(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
		send('0, 32'h00000001, '0, '0);
		send('0, 32'hffffffff, 32'hffffffff, '0);
		send(MAXV, '0, '0, MINV);
		send(32'h00000001, MAXV, MAXV, 32'h00000001);
		send(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
		send(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);

		// Random: mixed magnitudes, symmetric and skewed off-diagonals
		for (int n = 0; n < N_RANDOM; n++) begin
			idle_pct = (n >= 200 && n < 300) ? 0 : 38;
			if (n == 450) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (board.pending.size() != 0) @(posedge clk);
			end
			mode = $urandom_range(3);
			b = pick(mode);
			if ($urandom_range(1))
				send(pick(mode), b, b, pick(mode));
			else
				send(pick(mode), b, pick(mode), pick(mode));
		end
		in_valid <= 1'b0;

		// Drain, then allow the pipeline latency to pass
		while (board.pending.size() != 0) @(posedge clk);
		repeat (2 * DW + 40) @(posedge clk);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/psdp_pkg.sv
hw/rtl/psdp_sqrt_pipe.sv
hw/rtl/psdp_div_pipe.sv
hw/rtl/psd_projection_2x2.sv
test/tb_psd_projection_2x2.sv
